@@ rtl/fbs_pkg.sv @@
// Shared types, codes and constants for the firmware update block sequencer.
// Used by every module of the sequencer but fbs_ram; depends on nothing.
`default_nettype none

package fbs_pkg;

   // Block and flash geometry.
   localparam int BLOCK_BYTES       = 128;
   localparam int WORD_BYTES        = 8;
   localparam int WORDS_PER_BLOCK   = BLOCK_BYTES / WORD_BYTES;
   localparam int BLOCKS_PER_SECTOR = 4;
   localparam int SECTOR_BYTES      = 512;
   localparam int BYTE_IDX_W        = $clog2(BLOCK_BYTES);
   localparam int LANE_W            = $clog2(WORD_BYTES);
   localparam int WORD_IDX_W        = $clog2(WORDS_PER_BLOCK);
   localparam int BLOCK_SHIFT       = $clog2(BLOCK_BYTES);
   localparam int SECTOR_SHIFT      = $clog2(SECTOR_BYTES);
   localparam int SECTOR_SEL_W      = $clog2(BLOCKS_PER_SECTOR);

   // Field widths.
   localparam int TIMER_W     = 16;
   localparam int BLOCK_NUM_W = 16;
   localparam int VALUE_W     = 32;
   localparam int ADDR_W      = 32;
   localparam int BYTE_W      = 8;
   localparam int WORD_W      = WORD_BYTES * BYTE_W;
   localparam int BSUM_W      = BYTE_W + LANE_W;
   localparam int CODE_W      = 2;

   // Stream packing.
   localparam int REQ_FIELDS_W = VALUE_W + BYTE_IDX_W;
   localparam int REQ_DATA_W   = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_FIELDS_W = CODE_W + ADDR_W + WORD_W;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;

   // Register port.
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W  = 3;

   localparam logic [REG_IDX_W-1:0] REG_LENGTH_RETRY = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_BLOCK_RETRY  = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_SHORT_GAP    = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_LONG_GAP     = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_FINISH_RETRY = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_FAST_LINK    = 3'd5;
   localparam logic [REG_IDX_W-1:0] REG_IMAGE_BASE   = 3'd6;

   localparam logic [TIMER_W-1:0] LENGTH_RETRY_RESET = 16'd800;
   localparam logic [TIMER_W-1:0] BLOCK_RETRY_RESET  = 16'd100;
   localparam logic [TIMER_W-1:0] SHORT_GAP_RESET    = 16'd1;
   localparam logic [TIMER_W-1:0] LONG_GAP_RESET     = 16'd50;
   localparam logic [TIMER_W-1:0] FINISH_RETRY_RESET = 16'd125;
   localparam logic [ADDR_W-1:0]  IMAGE_BASE_RESET   = 32'h0000_4000;

   // Input operations.
   typedef enum logic [1:0] {
      OP_TICK     = 2'd0,
      OP_LENGTH   = 2'd1,
      OP_CHECKSUM = 2'd2,
      OP_DATA     = 2'd3
   } op_type;

   // Result actions and request codes.
   localparam logic [1:0] ACT_REQUEST = 2'd0;
   localparam logic [1:0] ACT_ERASE   = 2'd1;
   localparam logic [1:0] ACT_PROGRAM = 2'd2;

   localparam logic [CODE_W-1:0] REQ_NONE   = 2'd0;
   localparam logic [CODE_W-1:0] REQ_LENGTH = 2'd1;
   localparam logic [CODE_W-1:0] REQ_BLOCK  = 2'd2;
   localparam logic [CODE_W-1:0] REQ_DONE   = 2'd3;

   typedef struct packed {
      logic [TIMER_W-1:0] length_retry_ticks;
      logic [TIMER_W-1:0] block_retry_ticks;
      logic [TIMER_W-1:0] short_gap_ticks;
      logic [TIMER_W-1:0] long_gap_ticks;
      logic [TIMER_W-1:0] finish_retry_ticks;
      logic               fast_link;
      logic [ADDR_W-1:0]  image_base;
   } cfg_type;

   // Controller to datapath.
   typedef struct packed {
      logic capture;     // latch the accepted transaction
      logic apply;       // store length, checksum or data byte
      logic tick_step;   // advance timers and take one sequencer step
      logic load_erase;  // put the sector erase into the output register
      logic read_word;   // read one word of the block buffer
      logic load_word;   // put the program word into the output register
   } cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic is_tick;
      logic out_free;
      logic finish_block;
      logic need_erase;
      logic word_last;
   } sts_type;

endpackage

`default_nettype wire

@@ rtl/fbs_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package dependencies.
`default_nettype none

module fbs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ rtl/fbs_csr.sv @@
// Configuration registers behind the register bus port.
// Depends on fbs_pkg for register indexes, reset values and cfg_type.
`default_nettype none

module fbs_csr
   import fbs_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic      [CSR_DATA_W-1:0] prdata,
   output logic                       pready,
   output cfg_type                    cfg
);

   cfg_type cfg_ff, cfg_in;
   logic    wr_fire;
   logic [REG_IDX_W-1:0] reg_idx;

   assign pready  = 1'b1;
   assign wr_fire = psel & penable & pwrite & pready;
   assign reg_idx = paddr[CSR_ADDR_W-1:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_fire) begin
         unique case (reg_idx)
            REG_LENGTH_RETRY: cfg_in.length_retry_ticks = pwdata[TIMER_W-1:0];
            REG_BLOCK_RETRY:  cfg_in.block_retry_ticks  = pwdata[TIMER_W-1:0];
            REG_SHORT_GAP:    cfg_in.short_gap_ticks    = pwdata[TIMER_W-1:0];
            REG_LONG_GAP:     cfg_in.long_gap_ticks     = pwdata[TIMER_W-1:0];
            REG_FINISH_RETRY: cfg_in.finish_retry_ticks = pwdata[TIMER_W-1:0];
            REG_FAST_LINK:    cfg_in.fast_link          = pwdata[0];
            REG_IMAGE_BASE:   cfg_in.image_base         = pwdata[ADDR_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_LENGTH_RETRY: prdata = CSR_DATA_W'(cfg_ff.length_retry_ticks);
         REG_BLOCK_RETRY:  prdata = CSR_DATA_W'(cfg_ff.block_retry_ticks);
         REG_SHORT_GAP:    prdata = CSR_DATA_W'(cfg_ff.short_gap_ticks);
         REG_LONG_GAP:     prdata = CSR_DATA_W'(cfg_ff.long_gap_ticks);
         REG_FINISH_RETRY: prdata = CSR_DATA_W'(cfg_ff.finish_retry_ticks);
         REG_FAST_LINK:    prdata = CSR_DATA_W'(cfg_ff.fast_link);
         REG_IMAGE_BASE:   prdata = CSR_DATA_W'(cfg_ff.image_base);
         default:          prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.length_retry_ticks <= LENGTH_RETRY_RESET;
         cfg_ff.block_retry_ticks  <= BLOCK_RETRY_RESET;
         cfg_ff.short_gap_ticks    <= SHORT_GAP_RESET;
         cfg_ff.long_gap_ticks     <= LONG_GAP_RESET;
         cfg_ff.finish_retry_ticks <= FINISH_RETRY_RESET;
         cfg_ff.fast_link          <= 1'b0;
         cfg_ff.image_base         <= IMAGE_BASE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

@@ rtl/fbs_ctrl.sv @@
// Controller state machine: accepts transactions and drives the datapath
// through each sequencer step and block write-out. Depends on fbs_pkg.
`default_nettype none

module fbs_ctrl
   import fbs_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic in_valid,
   output logic      in_ready,
   input  sts_type   sts,
   output cmd_type   cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_ERASE,
      S_READ,
      S_WORD
   } state_type;

   state_type state_ff, state_in;

   assign in_ready = (state_ff == S_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (in_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            if (!sts.is_tick) begin
               cmd.apply = 1'b1;
               state_in  = S_IDLE;
            end else if (sts.out_free) begin
               // A tick may emit a request, so it waits for the output register.
               cmd.tick_step = 1'b1;
               if (sts.finish_block) begin
                  state_in = sts.need_erase ? S_ERASE : S_READ;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_ERASE: begin
            if (sts.out_free) begin
               cmd.load_erase = 1'b1;
               state_in       = S_READ;
            end
         end
         S_READ: begin
            cmd.read_word = 1'b1;
            state_in      = S_WORD;
         end
         S_WORD: begin
            if (sts.out_free) begin
               cmd.load_word = 1'b1;
               state_in      = sts.word_last ? S_IDLE : S_READ;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/fbs_datapath.sv @@
// Sequencer datapath: phase and timers, sums, block buffer and output register.
// Depends on fbs_pkg and instantiates fbs_ram for the buffer byte lanes.
`default_nettype none

module fbs_datapath
   import fbs_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  cfg_type                    cfg,
   input  cmd_type                    cmd,
   output sts_type                    sts,
   input  wire logic [1:0]            in_op,
   input  wire logic [VALUE_W-1:0]    in_value,
   input  wire logic [BYTE_IDX_W-1:0] in_index,
   input  wire logic                  in_done,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic      [1:0]            rsp_action,
   output logic      [CODE_W-1:0]     rsp_code,
   output logic      [ADDR_W-1:0]     rsp_addr,
   output logic      [WORD_W-1:0]     rsp_word,
   output logic                       rsp_last
);

   typedef enum logic [2:0] {
      PH_IDLE   = 3'd0,
      PH_LENGTH = 3'd1,
      PH_DATA   = 3'd2,
      PH_GAP    = 3'd3,
      PH_END    = 3'd4
   } phase_type;

   // Captured transaction.
   op_type                op_ff, op_in;
   logic [VALUE_W-1:0]    value_ff, value_in;
   logic [BYTE_IDX_W-1:0] index_ff, index_in;
   logic                  done_ff, done_in;

   // Sequencer state.
   phase_type             phase_ff, phase_in;
   logic [TIMER_W-1:0]    retry_ff, retry_in;
   logic [TIMER_W-1:0]    gap_ff, gap_in;
   logic [BLOCK_NUM_W-1:0] bnum_ff, bnum_in;
   logic [VALUE_W-1:0]    length_ff, length_in;
   logic [VALUE_W-1:0]    expect_ff, expect_in;
   logic [VALUE_W-1:0]    sum_ff, sum_in;
   logic                  ready_ff, ready_in;
   logic [BLOCK_BYTES-1:0] valid_ff, valid_in;
   logic [WORD_IDX_W-1:0] word_cnt_ff, word_cnt_in;
   logic [WORD_BYTES-1:0] vmask_ff, vmask_in;

   // Output register.
   logic                  out_valid_ff, out_valid_in;
   logic [1:0]            out_action_ff, out_action_in;
   logic [CODE_W-1:0]     out_code_ff, out_code_in;
   logic [ADDR_W-1:0]     out_addr_ff, out_addr_in;
   logic [WORD_W-1:0]     out_word_ff, out_word_in;
   logic                  out_last_ff, out_last_in;

   logic [TIMER_W-1:0]    retry_inc, gap_inc;
   logic [BYTE_W-1:0]     lane_q [WORD_BYTES];
   logic [WORD_W-1:0]     word_data;
   logic [BSUM_W-1:0]     byte_sum;
   logic [BLOCK_NUM_W:0]  bnum_next;
   logic [ADDR_W-1:0]     covered_bytes;
   logic                  last_block;
   logic [ADDR_W-1:0]     word_addr, sector_addr;
   logic                  out_free;
   logic                  buf_wr;

   assign retry_inc = (&retry_ff) ? retry_ff : retry_ff + 1'b1;
   assign gap_inc   = (&gap_ff) ? gap_ff : gap_ff + 1'b1;
   assign out_free  = !out_valid_ff || rsp_ready;

   // Each lane holds one byte position of every word, so a whole word is
   // read at once. Bytes not written since the last clear read as zero.
   assign buf_wr = cmd.apply && (op_ff == OP_DATA);

   for (genvar b = 0; b < WORD_BYTES; b++) begin : g_lane
      fbs_ram #(
         .WIDTH(BYTE_W),
         .DEPTH(WORDS_PER_BLOCK)
      ) u_lane (
         .clock  (clock),
         .wr_en  (buf_wr && (index_ff[LANE_W-1:0] == LANE_W'(b))),
         .wr_addr(index_ff[BYTE_IDX_W-1:LANE_W]),
         .wr_data(value_ff[BYTE_W-1:0]),
         .rd_en  (cmd.read_word),
         .rd_addr(word_cnt_ff),
         .rd_data(lane_q[b])
      );
      assign word_data[b*BYTE_W +: BYTE_W] = lane_q[b] & {BYTE_W{vmask_ff[b]}};
   end

   always_comb begin
      byte_sum = '0;
      for (int b = 0; b < WORD_BYTES; b++) begin
         byte_sum = byte_sum + BSUM_W'(word_data[b*BYTE_W +: BYTE_W]);
      end
   end

   // The block is the last one when (block_number + 1) blocks cover the image.
   assign bnum_next     = {1'b0, bnum_ff} + 1'b1;
   assign covered_bytes = ADDR_W'(bnum_next) << BLOCK_SHIFT;
   assign last_block    = covered_bytes >= length_ff;

   assign word_addr = cfg.image_base + ((ADDR_W'(bnum_ff) << BLOCK_SHIFT) |
                                        (ADDR_W'(word_cnt_ff) << LANE_W));
   assign sector_addr = cfg.image_base +
                        (ADDR_W'(bnum_ff[BLOCK_NUM_W-1:SECTOR_SEL_W]) << SECTOR_SHIFT);

   assign sts.is_tick      = (op_ff == OP_TICK);
   assign sts.out_free     = out_free;
   assign sts.finish_block = (phase_ff == PH_DATA) && ready_ff;
   assign sts.need_erase   = (bnum_ff[SECTOR_SEL_W-1:0] == '0);
   assign sts.word_last    = (word_cnt_ff == WORD_IDX_W'(WORDS_PER_BLOCK - 1));

   always_comb begin
      op_in       = op_ff;
      value_in    = value_ff;
      index_in    = index_ff;
      done_in     = done_ff;
      phase_in    = phase_ff;
      retry_in    = retry_ff;
      gap_in      = gap_ff;
      bnum_in     = bnum_ff;
      length_in   = length_ff;
      expect_in   = expect_ff;
      sum_in      = sum_ff;
      ready_in    = ready_ff;
      valid_in    = valid_ff;
      word_cnt_in = word_cnt_ff;
      vmask_in    = vmask_ff;

      out_valid_in  = out_valid_ff && !rsp_ready;
      out_action_in = out_action_ff;
      out_code_in   = out_code_ff;
      out_addr_in   = out_addr_ff;
      out_word_in   = out_word_ff;
      out_last_in   = out_last_ff;

      if (cmd.capture) begin
         op_in    = op_type'(in_op);
         value_in = in_value;
         index_in = in_index;
         done_in  = in_done;
      end

      if (cmd.apply) begin
         unique case (op_ff)
            OP_LENGTH:   length_in = value_ff;
            OP_CHECKSUM: expect_in = value_ff;
            OP_DATA: begin
               valid_in[index_ff] = 1'b1;
               if (done_ff) begin
                  ready_in = 1'b1;
               end
            end
            OP_TICK: ;
         endcase
      end

      if (cmd.tick_step) begin
         retry_in = retry_inc;
         gap_in   = gap_inc;
         unique case (phase_ff)
            PH_IDLE: begin
               retry_in      = '0;
               phase_in      = PH_LENGTH;
               out_valid_in  = 1'b1;
               out_action_in = ACT_REQUEST;
               out_code_in   = REQ_LENGTH;
               out_addr_in   = '0;
               out_word_in   = '0;
               out_last_in   = 1'b1;
            end
            PH_LENGTH: begin
               if (length_ff != '0) begin
                  bnum_in  = '0;
                  gap_in   = '0;
                  phase_in = PH_GAP;
               end else if (retry_inc >= cfg.length_retry_ticks) begin
                  retry_in      = '0;
                  out_valid_in  = 1'b1;
                  out_action_in = ACT_REQUEST;
                  out_code_in   = REQ_LENGTH;
                  out_addr_in   = '0;
                  out_word_in   = '0;
                  out_last_in   = 1'b1;
               end
            end
            PH_DATA: begin
               // A ready block is written out by the following commands.
               if (!ready_ff && (retry_inc >= cfg.block_retry_ticks)) begin
                  retry_in = '0;
                  gap_in   = '0;
                  phase_in = PH_GAP;
               end
            end
            PH_GAP: begin
               if ((gap_inc >= cfg.short_gap_ticks && cfg.fast_link) ||
                   gap_inc >= cfg.long_gap_ticks) begin
                  phase_in      = PH_DATA;
                  out_valid_in  = 1'b1;
                  out_action_in = ACT_REQUEST;
                  out_code_in   = REQ_BLOCK;
                  out_addr_in   = '0;
                  out_word_in   = '0;
                  out_last_in   = 1'b1;
               end
            end
            PH_END: begin
               if (retry_inc >= cfg.finish_retry_ticks) begin
                  retry_in = '0;
                  if (sum_ff == expect_ff) begin
                     out_valid_in  = 1'b1;
                     out_action_in = ACT_REQUEST;
                     out_code_in   = REQ_DONE;
                     out_addr_in   = '0;
                     out_word_in   = '0;
                     out_last_in   = 1'b1;
                  end else begin
                     // Checksum mismatch: start the whole download over.
                     phase_in  = PH_IDLE;
                     gap_in    = '0;
                     bnum_in   = '0;
                     length_in = '0;
                     expect_in = '0;
                     sum_in    = '0;
                     ready_in  = 1'b0;
                     valid_in  = '0;
                  end
               end
            end
            default: ;
         endcase
      end

      if (cmd.load_erase) begin
         out_valid_in  = 1'b1;
         out_action_in = ACT_ERASE;
         out_code_in   = REQ_NONE;
         out_addr_in   = sector_addr;
         out_word_in   = '0;
         out_last_in   = 1'b0;
      end

      if (cmd.read_word) begin
         for (int b = 0; b < WORD_BYTES; b++) begin
            vmask_in[b] = valid_ff[{word_cnt_ff, LANE_W'(b)}];
         end
      end

      if (cmd.load_word) begin
         out_valid_in  = 1'b1;
         out_action_in = ACT_PROGRAM;
         out_code_in   = REQ_NONE;
         out_addr_in   = word_addr;
         out_word_in   = word_data;
         out_last_in   = sts.word_last;
         sum_in        = sum_ff + VALUE_W'(byte_sum);
         word_cnt_in   = word_cnt_ff + 1'b1;
         if (sts.word_last) begin
            valid_in = '0;
            ready_in = 1'b0;
            if (last_block) begin
               retry_in = '0;
               phase_in = PH_END;
            end else begin
               bnum_in  = bnum_next[BLOCK_NUM_W-1:0];
               gap_in   = '0;
               phase_in = PH_GAP;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         retry_ff     <= '0;
         gap_ff       <= '0;
         bnum_ff      <= '0;
         length_ff    <= '0;
         expect_ff    <= '0;
         sum_ff       <= '0;
         ready_ff     <= 1'b0;
         valid_ff     <= '0;
         word_cnt_ff  <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         retry_ff     <= retry_in;
         gap_ff       <= gap_in;
         bnum_ff      <= bnum_in;
         length_ff    <= length_in;
         expect_ff    <= expect_in;
         sum_ff       <= sum_in;
         ready_ff     <= ready_in;
         valid_ff     <= valid_in;
         word_cnt_ff  <= word_cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      value_ff      <= value_in;
      index_ff      <= index_in;
      done_ff       <= done_in;
      vmask_ff      <= vmask_in;
      out_action_ff <= out_action_in;
      out_code_ff   <= out_code_in;
      out_addr_ff   <= out_addr_in;
      out_word_ff   <= out_word_in;
      out_last_ff   <= out_last_in;
   end

   assign rsp_valid  = out_valid_ff;
   assign rsp_action = out_action_ff;
   assign rsp_code   = out_code_ff;
   assign rsp_addr   = out_addr_ff;
   assign rsp_word   = out_word_ff;
   assign rsp_last   = out_last_ff;

endmodule

`default_nettype wire

@@ rtl/firmware_update_block_sequencer_core.sv @@
// A transaction is captured in S_IDLE and executed in S_EXEC, where a tick waits for a free
// output register; a request result is loaded into the output register by that step.
// A new transaction is taken only once the last one has been executed; a tick that completes
// a block adds an optional sector erase and sixteen program words, each a buffer read and an
// output load. A waiting result stalls the controller.
// Reset clears the sequencer state bar the word mask, the buffer valid bits and the registers at once.
`default_nettype none

module firmware_update_block_sequencer_core
   import fbs_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // Input stream.
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,  // value[31:0], byte_index[38:32], zero pad
   input  wire logic [1:0]            req_tuser,  // operation[1:0]
   input  wire logic                  req_tlast,  // block_done
   // Result stream.
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic      [RSP_DATA_W-1:0] rsp_tdata,  // request_code[1:0], flash_address[33:2],
                                                  // data_word[97:34], zero pad
   output logic      [1:0]            rsp_tuser,  // action[1:0]
   output logic                       rsp_tlast,  // last
   // Register port.
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready
);

   cfg_type cfg;
   cmd_type cmd;
   sts_type sts;

   logic [CODE_W-1:0] rsp_code;
   logic [ADDR_W-1:0] rsp_addr;
   logic [WORD_W-1:0] rsp_word;

   fbs_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .psel   (csr_psel),
      .penable(csr_penable),
      .pwrite (csr_pwrite),
      .paddr  (csr_paddr),
      .pwdata (csr_pwdata),
      .prdata (csr_prdata),
      .pready (csr_pready),
      .cfg    (cfg)
   );

   fbs_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .in_valid(req_tvalid),
      .in_ready(req_tready),
      .sts     (sts),
      .cmd     (cmd)
   );

   fbs_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .cmd       (cmd),
      .sts       (sts),
      .in_op     (req_tuser),
      .in_value  (req_tdata[VALUE_W-1:0]),
      .in_index  (req_tdata[VALUE_W +: BYTE_IDX_W]),
      .in_done   (req_tlast),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_action(rsp_tuser),
      .rsp_code  (rsp_code),
      .rsp_addr  (rsp_addr),
      .rsp_word  (rsp_word),
      .rsp_last  (rsp_tlast)
   );

   assign rsp_tdata = RSP_DATA_W'({rsp_word, rsp_addr, rsp_code});

endmodule

`default_nettype wire

@@ verif/firmware_update_block_sequencer_core_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for firmware_update_block_sequencer_core: streams ticks, lengths,
// checksums and data bytes into the block and checks every request, erase and program word.
// Depends on fbs_pkg and the core RTL only.

module firmware_update_block_sequencer_core_tb
   import fbs_pkg::*;
();

   localparam int IDLE_SETTLE  = 8;
   localparam int END_SETTLE   = 40;
   localparam int PHASE_ITEMS  = 125;
   localparam logic [REG_IDX_W-1:0] REG_UNUSED = 3'd7;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'd0,
      ST_LENGTH = 3'd1,
      ST_DATA   = 3'd2,
      ST_GAP    = 3'd3,
      ST_END    = 3'd4
   } stage_type;

   typedef struct packed {
      logic [1:0]  action;
      logic [1:0]  code;
      logic [31:0] addr;
      logic [63:0] word;
      logic        is_last;
   } flash_op_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;   // value[31:0], byte_index[38:32], zero pad
   logic [1:0]            req_tuser;   // operation[1:0]
   logic                  req_tlast;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;   // request_code[1:0], flash_address[33:2], data_word[97:34]
   logic [1:0]            rsp_tuser;   // action[1:0]
   logic                  rsp_tlast;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   firmware_update_block_sequencer_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Mirror of the sequencer state and its registers.
   cfg_type            model_cfg;
   stage_type          m_stage;
   logic [15:0]        m_retry;
   logic [15:0]        m_gap;
   logic [15:0]        m_blk_num;
   logic [31:0]        m_img_len;
   logic [31:0]        m_exp_sum;
   logic [31:0]        m_run_sum;
   logic               m_blk_ready;
   logic [7:0]         m_blk_buf [0:BLOCK_BYTES-1];

   flash_op_type expected_flash_ops[$];

   int idle_pct = 8;
   int errors = 0;
   int n_sent = 0;
   int n_checked = 0;
   int n_blocks = 0;
   int n_done = 0;
   int n_restarts = 0;
   bit checksum_sent = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("%0t: run did not complete in time, %0d results outstanding", $time,
               expected_flash_ops.size());
      $display("Mismatches found");
      $finish;
   end

   function automatic void add_op(input logic [1:0] action, input logic [1:0] code,
                                  input logic [31:0] addr, input logic [63:0] word);
      flash_op_type op;
      op = '{action: action, code: code, addr: addr, word: word, is_last: 1'b0};
      expected_flash_ops.push_back(op);
   endfunction

   task automatic clear_sequencer_state();
      m_stage     = ST_IDLE;
      m_retry     = '0;
      m_gap       = '0;
      m_blk_num   = '0;
      m_img_len   = '0;
      m_exp_sum   = '0;
      m_run_sum   = '0;
      m_blk_ready = 1'b0;
      foreach (m_blk_buf[b]) m_blk_buf[b] = '0;
   endtask

   // Works out the results of one accepted transaction and queues them in order.
   task automatic sequencer_predict(input op_type op, input logic [31:0] value,
                                    input logic [6:0] idx, input logic done);
      int           first;
      int           i;
      int           k;
      logic [63:0]  w;
      logic [63:0]  blocks;
      flash_op_type tail;
      first = expected_flash_ops.size();
      case (op)
         OP_TICK: begin
            if (m_retry != 16'hFFFF) m_retry++;
            if (m_gap != 16'hFFFF) m_gap++;
            case (m_stage)
               ST_IDLE: begin
                  add_op(ACT_REQUEST, REQ_LENGTH, '0, '0);
                  m_retry = '0;
                  m_stage = ST_LENGTH;
               end
               ST_LENGTH: begin
                  if (m_img_len != 0) begin
                     m_blk_num = '0;
                     m_gap     = '0;
                     m_stage   = ST_GAP;
                  end else if (m_retry >= model_cfg.length_retry_ticks) begin
                     m_retry = '0;
                     add_op(ACT_REQUEST, REQ_LENGTH, '0, '0);
                  end
               end
               ST_DATA: begin
                  if (m_blk_ready) begin
                     for (i = 0; i < BLOCK_BYTES; i++) m_run_sum += 32'(m_blk_buf[i]);
                     if ((32'(m_blk_num) % BLOCKS_PER_SECTOR) == 0)
                        add_op(ACT_ERASE, REQ_NONE, model_cfg.image_base +
                               (32'(m_blk_num) / BLOCKS_PER_SECTOR) * SECTOR_BYTES, '0);
                     for (k = 0; k < WORDS_PER_BLOCK; k++) begin
                        w = '0;
                        for (i = 0; i < WORD_BYTES; i++)
                           w[8*i +: 8] = m_blk_buf[k*WORD_BYTES + i];
                        add_op(ACT_PROGRAM, REQ_NONE, model_cfg.image_base +
                               32'(m_blk_num) * BLOCK_BYTES + 32'(k * WORD_BYTES), w);
                     end
                     m_blk_ready = 1'b0;
                     foreach (m_blk_buf[b]) m_blk_buf[b] = '0;
                     n_blocks++;
                     blocks = (64'(m_img_len) + BLOCK_BYTES - 1) / BLOCK_BYTES;
                     if (64'(m_blk_num) + 1 >= blocks) begin
                        m_retry = '0;
                        m_stage = ST_END;
                     end else begin
                        m_blk_num++;
                        m_gap   = '0;
                        m_stage = ST_GAP;
                     end
                  end else if (m_retry >= model_cfg.block_retry_ticks) begin
                     m_retry = '0;
                     m_gap   = '0;
                     m_stage = ST_GAP;
                  end
               end
               ST_GAP: begin
                  if ((m_gap >= model_cfg.short_gap_ticks && model_cfg.fast_link) ||
                      m_gap >= model_cfg.long_gap_ticks) begin
                     m_stage = ST_DATA;
                     add_op(ACT_REQUEST, REQ_BLOCK, '0, '0);
                  end
               end
               ST_END: begin
                  if (m_retry >= model_cfg.finish_retry_ticks) begin
                     m_retry = '0;
                     if (m_run_sum == m_exp_sum) begin
                        add_op(ACT_REQUEST, REQ_DONE, '0, '0);
                        n_done++;
                     end else begin
                        clear_sequencer_state();
                        n_restarts++;
                     end
                  end
               end
               default: ;
            endcase
         end
         OP_LENGTH:   m_img_len = value;
         OP_CHECKSUM: m_exp_sum = value;
         default: begin
            m_blk_buf[idx] = value[7:0];
            if (done) m_blk_ready = 1'b1;
         end
      endcase
      if (expected_flash_ops.size() > first) begin
         tail = expected_flash_ops.pop_back();
         tail.is_last = 1'b1;
         expected_flash_ops.push_back(tail);
      end
   endtask

   // Called at a falling edge; returns at the falling edge after the transaction is taken.
   task automatic send_item(input op_type op, input logic [31:0] value,
                            input logic [6:0] idx, input logic done);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= REQ_DATA_W'({idx, value});
      req_tlast  <= done;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sequencer_predict(op, value, idx, done);
      n_sent++;
      @(negedge clock);
   endtask

   task automatic send_tick();
      send_item(OP_TICK, $urandom, 7'($urandom_range(127)), 1'($urandom_range(1)));
   endtask

   // Leaves psel high so that back-to-back writes never toggle it within one step.
   task automatic csr_write(input logic [REG_IDX_W-1:0] reg_idx, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {reg_idx, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      case (reg_idx)
         REG_LENGTH_RETRY: model_cfg.length_retry_ticks = value[15:0];
         REG_BLOCK_RETRY:  model_cfg.block_retry_ticks  = value[15:0];
         REG_SHORT_GAP:    model_cfg.short_gap_ticks    = value[15:0];
         REG_LONG_GAP:     model_cfg.long_gap_ticks     = value[15:0];
         REG_FINISH_RETRY: model_cfg.finish_retry_ticks = value[15:0];
         REG_FAST_LINK:    model_cfg.fast_link          = value[0];
         REG_IMAGE_BASE:   model_cfg.image_base         = value;
         default: ;
      endcase
      @(negedge clock);
   endtask

   // Unused upper bits of the narrow registers carry random junk.
   task automatic set_timing(input logic [15:0] length_retry, input logic [15:0] block_retry,
                             input logic [15:0] short_gap, input logic [15:0] long_gap,
                             input logic [15:0] finish_retry, input logic fast,
                             input logic [31:0] base);
      csr_write(REG_LENGTH_RETRY, {16'($urandom), length_retry});
      csr_write(REG_BLOCK_RETRY,  {16'($urandom), block_retry});
      csr_write(REG_SHORT_GAP,    {16'($urandom), short_gap});
      csr_write(REG_LONG_GAP,     {16'($urandom), long_gap});
      csr_write(REG_FINISH_RETRY, {16'($urandom), finish_retry});
      csr_write(REG_FAST_LINK,    {31'($urandom), fast});
      csr_write(REG_IMAGE_BASE,   base);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   // Holds the input off until every queued result has been taken and the block has settled.
   task automatic wait_until_idle();
      req_tvalid <= 1'b0;
      while (expected_flash_ops.size() != 0) @(posedge clock);
      repeat (IDLE_SETTLE) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic logic [31:0] pick_image_length();
      if ($urandom_range(3) == 0) return 32'(BLOCK_BYTES * $urandom_range(1, 6));
      return 32'($urandom_range(1, 6 * BLOCK_BYTES));
   endfunction

   task automatic test_reset_length_request();
      send_tick();
      // block_done travels with a tick and a checksum here and must be ignored.
      send_item(OP_TICK, 32'h0, 7'd0, 1'b1);
      send_item(OP_CHECKSUM, 32'h0, 7'd127, 1'b1);
      wait_until_idle();
   endtask

   task automatic test_directed_download();
      csr_write(REG_UNUSED, $urandom);
      set_timing(LENGTH_RETRY_RESET, BLOCK_RETRY_RESET, 16'd0, LONG_GAP_RESET, 16'd1, 1'b1,
                 IMAGE_BASE_RESET);
      // A huge image keeps the first block from being the last one.
      send_item(OP_LENGTH, 32'hFFFF_FFFF, 7'd0, 1'b0);
      send_tick();
      send_tick();
      send_item(OP_DATA, 32'hFFFF_FFFF, 7'd0, 1'b0);
      send_item(OP_DATA, 32'hABCD_EF5A, 7'd127, 1'b0);
      send_item(OP_LENGTH, 32'hFFFF_FFFF, 7'd64, 1'b1);
      send_item(OP_DATA, 32'h0000_00C3, 7'd64, 1'b1);
      send_tick();
      send_item(OP_LENGTH, 32'd130, 7'd0, 1'b0);
      send_tick();
      send_item(OP_DATA, 32'h0000_0080, 7'd5, 1'b1);
      send_tick();
      send_item(OP_CHECKSUM, m_run_sum, 7'd0, 1'b0);
      send_tick();
      send_tick();
      // A wrong checksum clears everything and the length is asked for again.
      send_item(OP_CHECKSUM, m_run_sum + 32'd1, 7'd0, 1'b0);
      send_tick();
      send_tick();
      wait_until_idle();
   endtask

   // Mostly well-formed downloads steered by the mirrored stage, with some random noise.
   task automatic test_random_download(input int n_items);
      int          i;
      int          pick;
      logic [31:0] v;
      op_type      op;
      for (i = 0; i < n_items; i++) begin
         pick = $urandom_range(99);
         if (m_stage != ST_END) checksum_sent = 0;
         if (pick < 10) begin
            op = op_type'($urandom_range(3));
            v  = $urandom;
            if (op == OP_LENGTH && $urandom_range(3) != 0) v = pick_image_length();
            send_item(op, v, 7'($urandom_range(127)), 1'($urandom_range(1)));
         end else begin
            case (m_stage)
               ST_IDLE, ST_LENGTH: begin
                  if (pick < 75) send_tick();
                  else send_item(OP_LENGTH, pick_image_length(), 7'($urandom_range(127)),
                                 1'($urandom_range(1)));
               end
               ST_GAP: begin
                  if (pick < 90) send_tick();
                  else send_item(OP_DATA, $urandom, 7'($urandom_range(127)), 1'b0);
               end
               ST_DATA: begin
                  if (m_img_len > 32'(8 * BLOCK_BYTES) && pick < 20)
                     send_item(OP_LENGTH, pick_image_length(), 7'd0, 1'b0);
                  else if (m_blk_ready || pick < 35)
                     send_tick();
                  else
                     send_item(OP_DATA, $urandom, 7'($urandom_range(127)),
                               $urandom_range(5) == 0);
               end
               ST_END: begin
                  if (!checksum_sent) begin
                     v = ($urandom_range(4) == 0) ? $urandom : m_run_sum;
                     send_item(OP_CHECKSUM, v, 7'($urandom_range(127)), 1'($urandom_range(1)));
                     checksum_sent = 1;
                  end else begin
                     send_tick();
                  end
               end
               default: send_tick();
            endcase
         end
      end
      wait_until_idle();
   endtask

   task automatic report_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
      if (want !== got) begin
         errors++;
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      end
   endtask

   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_tready <= ($urandom_range(99) >= idle_pct);
      end
   end

   always @(posedge clock) begin
      flash_op_type got;
      flash_op_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tuser, rsp_tdata[1:0], rsp_tdata[33:2], rsp_tdata[97:34], rsp_tlast};
         n_checked++;
         if (expected_flash_ops.size() == 0) begin
            errors++;
            $display("%0t: result with nothing expected, expected none, actual 0x%0h",
                     $time, got);
         end else begin
            want = expected_flash_ops.pop_front();
            report_field("action", 64'(want.action), 64'(got.action));
            report_field("request_code", 64'(want.code), 64'(got.code));
            report_field("flash_address", 64'(want.addr), 64'(got.addr));
            report_field("data_word", want.word, got.word);
            report_field("last", 64'(want.is_last), 64'(got.is_last));
         end
      end
   end

   initial begin
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = '0;
      req_tlast   = 1'b0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      reset       = 1'b1;
      model_cfg = '{length_retry_ticks: LENGTH_RETRY_RESET, block_retry_ticks: BLOCK_RETRY_RESET,
                    short_gap_ticks: SHORT_GAP_RESET, long_gap_ticks: LONG_GAP_RESET,
                    finish_retry_ticks: FINISH_RETRY_RESET, fast_link: 1'b0,
                    image_base: IMAGE_BASE_RESET};
      clear_sequencer_state();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_reset_length_request();
      test_directed_download();

      set_timing(16'd3, 16'd12, 16'd1, 16'd6, 16'd2, 1'b0, IMAGE_BASE_RESET);
      test_random_download(PHASE_ITEMS);

      // Extreme timers with the address space wrapping, and no idling on either side.
      idle_pct = 0;
      set_timing(16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 1'b1, 32'hFFFF_FFFF);
      test_random_download(PHASE_ITEMS);
      idle_pct = 8;

      set_timing(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0, 32'h0000_0000);
      test_random_download(PHASE_ITEMS);

      set_timing(16'($urandom_range(0, 8)), 16'($urandom_range(2, 30)),
                 16'($urandom_range(0, 4)), 16'($urandom_range(0, 12)),
                 16'($urandom_range(0, 6)), 1'($urandom_range(1)), $urandom);
      test_random_download(PHASE_ITEMS);

      wait_until_idle();
      repeat (END_SETTLE) @(posedge clock);

      $display("Drove %0d input transactions and checked %0d result transactions.",
               n_sent, n_checked);
      $display("Programmed %0d blocks, saw %0d done requests and %0d checksum restarts.",
               n_blocks, n_done, n_restarts);
      if (errors == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
